FILE: src/iws_pkg.sv
// iws_pkg: shared widths, payload types and register codes for the inverse
// wavelet synthesis block; no dependencies, compiled first
package iws_pkg;

	localparam int SMP_W     = 16;  // sample and coefficient width
	localparam int PROD_W    = 32;  // exact 16 x 16 product
	localparam int SUM_W     = 36;  // exact sum of up to sixteen products
	localparam int FRAC_BITS = 14;  // Q1.14 coefficients
	localparam int NUM_REGS  = 8;   // tap coefficient registers
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	localparam logic [CFG_IDX_W-1:0] REG_TAP0 = CFG_IDX_W'(0);

	// one input item as it travels down the cell row
	typedef struct packed {
		logic signed [SMP_W-1:0] d;
		logic signed [SMP_W-1:0] a;
	} sample_pair_t;

	// four Q1.14 coefficients of one tap, f00 in the lowest bits
	typedef struct packed {
		logic signed [SMP_W-1:0] f11;
		logic signed [SMP_W-1:0] f10;
		logic signed [SMP_W-1:0] f01;
		logic signed [SMP_W-1:0] f00;
	} coef_set_t;

	// registered products of one tap
	typedef struct packed {
		logic signed [PROD_W-1:0] p11;
		logic signed [PROD_W-1:0] p10;
		logic signed [PROD_W-1:0] p01;
		logic signed [PROD_W-1:0] p00;
	} prod_set_t;

endpackage

FILE: src/iws_cell.sv
// iws_cell: one tap of the synthesis filter row; holds the tap coefficients
// and one history item, registers its four products; uses iws_pkg
module iws_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [iws_pkg::CFG_W-1:0] cfg_data,
	input  logic                     shift,
	input  logic                     adv,
	input  iws_pkg::sample_pair_t    x_in,
	output iws_pkg::sample_pair_t    x_out,
	output iws_pkg::prod_set_t       prod_s1
);
	import iws_pkg::*;

	coef_set_t    coef_q;
	sample_pair_t x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			coef_q <= coef_set_t'(cfg_data);
		end
	end

	// history item handed on to the next tap
	always_ff @(posedge clk) begin
		if (shift) begin
			x_q <= x_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1.p00 <= PROD_W'(x_in.a) * PROD_W'(coef_q.f00);
			prod_s1.p01 <= PROD_W'(x_in.a) * PROD_W'(coef_q.f01);
			prod_s1.p10 <= PROD_W'(x_in.d) * PROD_W'(coef_q.f10);
			prod_s1.p11 <= PROD_W'(x_in.d) * PROD_W'(coef_q.f11);
		end
	end

	assign x_out = x_q;

endmodule

FILE: src/iws_adder_tree.sv
// iws_adder_tree: registered binary adder tree over the tap products,
// one register level per tree level; uses iws_pkg
module iws_adder_tree #(
	parameter int N = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [iws_pkg::SUM_W-1:0] leaf [N],
	output logic                             out_valid,
	output logic signed [iws_pkg::SUM_W-1:0] sum
);
	import iws_pkg::*;

	localparam int LVL = $clog2(N);
	localparam int P   = 1 << LVL;

	logic signed [SUM_W-1:0] leaf_pad [P];
	logic signed [SUM_W-1:0] node_q [1:P-1];
	logic [LVL-1:0]          vld_q;

	always_comb begin
		for (int i = 0; i < P; i++) begin
			leaf_pad[i] = (i < N) ? leaf[i] : '0;
		end
	end

	for (genvar i = 1; i < P; i++) begin : g_node
		if (2 * i >= P) begin : g_leafs
			always_ff @(posedge clk) begin
				if (en) begin
					node_q[i] <= leaf_pad[2*i-P] + leaf_pad[2*i+1-P];
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (en) begin
					node_q[i] <= node_q[2*i] + node_q[2*i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LVL-2:0], in_valid};
		end
	end

	assign sum       = node_q[1];
	assign out_valid = vld_q[LVL-1];

endmodule

FILE: src/iws_out.sv
// iws_out: rounds, shifts and saturates both sums of an item and sends the
// two samples one after the other; uses iws_pkg
module iws_out (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [iws_pkg::SUM_W-1:0] sum_first,
	input  logic signed [iws_pkg::SUM_W-1:0] sum_second,
	output logic                             ready,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [iws_pkg::SMP_W-1:0]        m_axis_tdata,
	output logic                             m_axis_tlast,
	output logic                             m_axis_tuser
);
	import iws_pkg::*;

	localparam int Q_W = SUM_W - FRAC_BITS;
	localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
	localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

	logic             full_q;
	logic             phase_q;
	logic [SMP_W-1:0] smp_q [2];
	logic             sat_q [2];
	logic [SMP_W-1:0] smp_c [2];
	logic             sat_c [2];
	logic             take;

	function automatic logic [SMP_W:0] round_sat(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] v;
		logic signed [Q_W-1:0]   q;
		v = s + HALF;
		q = Q_W'(v >>> FRAC_BITS);
		if (q > Q_MAX) begin
			return {1'b1, Q_MAX[SMP_W-1:0]};
		end else if (q < Q_MIN) begin
			return {1'b1, Q_MIN[SMP_W-1:0]};
		end
		return {1'b0, q[SMP_W-1:0]};
	endfunction

	always_comb begin
		{sat_c[0], smp_c[0]} = round_sat(sum_first);
		{sat_c[1], smp_c[1]} = round_sat(sum_second);
	end

	assign take  = full_q && m_axis_tready;
	assign ready = !full_q || (take && phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (ready && in_valid) begin
			full_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (take) begin
			full_q  <= !phase_q;
			phase_q <= !phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && in_valid) begin
			smp_q <= smp_c;
			sat_q <= sat_c;
		end
	end

	assign m_axis_tvalid = full_q;
	assign m_axis_tdata  = smp_q[phase_q];
	assign m_axis_tlast  = phase_q;
	assign m_axis_tuser  = sat_q[phase_q];

endmodule

FILE: src/inverse_wavelet_synthesis.sv
// inverse_wavelet_synthesis: top level, a row of TAPS filter cells, two
// adder trees and the output pair register; uses iws_pkg and all iws_ modules
// an item's products are registered in the cells, summed through the adder
// tree registers and held in the pair register; the second sample goes one
// transfer after the first. The cell row takes one item per cycle while the
// pair register can take a new pair, sustained rate set by the single output channel
// reset: arst_n clears the coefficients, the fill count and all valid flags
module inverse_wavelet_synthesis #(
	parameter int TAPS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [2*iws_pkg::SMP_W-1:0]   s_axis_tdata,  // approx_coef, detail_coef
	input  logic                          s_axis_tuser,  // block_start
	// output stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [iws_pkg::SMP_W-1:0]     m_axis_tdata,  // out_sample
	output logic                          m_axis_tlast,  // out_last
	output logic                          m_axis_tuser,  // saturated
	// coefficient write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [iws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [iws_pkg::CFG_W-1:0]     cfg_data
);
	import iws_pkg::*;

	localparam int FILL_W = $clog2(TAPS);
	localparam int LEAVES = 2 * TAPS;
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS - 1);

	// pipeline control
	logic adv;        // whole pipeline moves one step
	logic accept;     // input transfer
	logic emit;       // accepted item yields a sample pair
	logic vld_s1;     // products of a pair-yielding item sit in the cells

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_eff;

	sample_pair_t x_chain [TAPS];
	prod_set_t    prod_s1 [TAPS];

	logic signed [SUM_W-1:0] leaf_first  [LEAVES];
	logic signed [SUM_W-1:0] leaf_second [LEAVES];
	logic signed [SUM_W-1:0] sum_first;
	logic signed [SUM_W-1:0] sum_second;
	logic                    tree_vld_first;
	logic                    tree_vld_second;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	// fill count: a block start restarts warmup before the item is counted
	assign fill_eff = s_axis_tuser ? '0 : fill_q;
	assign emit     = (fill_eff == FILL_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= emit ? fill_eff : fill_eff + FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept && emit;
		end
	end

	// the newest item enters tap 0; each cell passes its held item on
	assign x_chain[0] = sample_pair_t'({s_axis_tdata[2*SMP_W-1:SMP_W],
	                                    s_axis_tdata[SMP_W-1:0]});

	for (genvar t = 0; t < TAPS; t++) begin : g_tap
		logic cfg_we;
		assign cfg_we = cfg_valid && (cfg_index == REG_TAP0 + CFG_IDX_W'(t));

		if (t < TAPS - 1) begin : g_mid
			iws_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cfg_we   (cfg_we),
				.cfg_data (cfg_data),
				.shift    (accept),
				.adv      (adv),
				.x_in     (x_chain[t]),
				.x_out    (x_chain[t+1]),
				.prod_s1  (prod_s1[t])
			);
		end else begin : g_end
			iws_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cfg_we   (cfg_we),
				.cfg_data (cfg_data),
				.shift    (accept),
				.adv      (adv),
				.x_in     (x_chain[t]),
				.x_out    (),
				.prod_s1  (prod_s1[t])
			);
		end

		// first sample uses f01/f11, second uses f00/f10
		assign leaf_first[2*t]    = SUM_W'(prod_s1[t].p01);
		assign leaf_first[2*t+1]  = SUM_W'(prod_s1[t].p11);
		assign leaf_second[2*t]   = SUM_W'(prod_s1[t].p00);
		assign leaf_second[2*t+1] = SUM_W'(prod_s1[t].p10);
	end

	iws_adder_tree #(.N(LEAVES)) u_tree_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s1),
		.leaf      (leaf_first),
		.out_valid (tree_vld_first),
		.sum       (sum_first)
	);

	iws_adder_tree #(.N(LEAVES)) u_tree_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s1),
		.leaf      (leaf_second),
		.out_valid (tree_vld_second),
		.sum       (sum_second)
	);

	// pair register; the pipeline moves whenever it can take a new pair
	iws_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (tree_vld_first),
		.sum_first     (sum_first),
		.sum_second    (sum_second),
		.ready         (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// both trees run in lock step
	a_trees_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		tree_vld_first == tree_vld_second)
		else $error("adder trees out of step");

	// fill count never passes the warmup length
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count out of range");

	// a block start leaves exactly one item counted
	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tuser |=> fill_q == FILL_W'(1))
		else $error("block start did not restart warmup");

	// the first sample of a pair is always followed by its second
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
		else $error("second sample of pair missing");

	// input is held off only while a pair is still waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

endmodule

FILE: tb/sv/inverse_wavelet_synthesis_chk.sv
// inverse_wavelet_synthesis_chk: watches the coefficient, input and output
// channels, predicts the synthesised samples and compares them; uses iws_pkg
`timescale 1ns / 100ps

module inverse_wavelet_synthesis_chk #(
	parameter int TAPS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [2*iws_pkg::SMP_W-1:0]   s_axis_tdata,  // approx_coef, detail_coef
	input  logic                          s_axis_tuser,  // block_start
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [iws_pkg::SMP_W-1:0]     m_axis_tdata,  // out_sample
	input  logic                          m_axis_tlast,  // out_last
	input  logic                          m_axis_tuser,  // saturated
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [iws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [iws_pkg::CFG_W-1:0]     cfg_data,
	output int                            errors,
	output int                            pending,
	output int                            items_seen,
	output int                            restarts_seen,
	output int                            samples_seen,
	output int                            clipped_seen
);

	import iws_pkg::*;

	typedef struct packed {
		logic [SMP_W-1:0] sample;
		logic             last;
		logic             sat;
	} synth_sample_t;

	logic [CFG_W-1:0]        coef_bank [NUM_REGS];
	logic signed [SMP_W-1:0] a_hist    [TAPS-1];
	logic signed [SMP_W-1:0] d_hist    [TAPS-1];
	int                      fill_cnt;
	synth_sample_t           expected_samples [$];
	int                      err_cnt, n_items, n_restarts, n_samples, n_clipped;

	// round half up, drop the fraction, clip to 16 bits
	function automatic synth_sample_t round_clip(input longint acc, input logic last);
		longint        q;
		synth_sample_t r;
		q = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		r.last = last;
		r.sat  = 1'b0;
		if (q > 32767) begin
			q     = 32767;
			r.sat = 1'b1;
		end else if (q < -32768) begin
			q     = -32768;
			r.sat = 1'b1;
		end
		r.sample = q[SMP_W-1:0];
		return r;
	endfunction

	// one coefficient pair in: push its sample pair once warm, shift history
	task automatic absorb_pair(input logic signed [SMP_W-1:0] a,
			input logic signed [SMP_W-1:0] d, input logic start);
		longint                  acc_first, acc_second;
		coef_set_t               c;
		logic signed [SMP_W-1:0] xa, xd;
		if (start)
			fill_cnt = 0;
		if (fill_cnt >= TAPS - 1) begin
			acc_first  = 0;
			acc_second = 0;
			for (int t = 0; t < TAPS; t++) begin
				c  = coef_bank[t];
				xa = (t == 0) ? a : a_hist[t-1];
				xd = (t == 0) ? d : d_hist[t-1];
				acc_first  += longint'(c.f01) * longint'(xa) + longint'(c.f11) * longint'(xd);
				acc_second += longint'(c.f00) * longint'(xa) + longint'(c.f10) * longint'(xd);
			end
			expected_samples.push_back(round_clip(acc_first, 1'b0));
			expected_samples.push_back(round_clip(acc_second, 1'b1));
		end else begin
			fill_cnt++;
		end
		for (int t = TAPS - 2; t > 0; t--) begin
			a_hist[t] = a_hist[t-1];
			d_hist[t] = d_hist[t-1];
		end
		a_hist[0] = a;
		d_hist[0] = d;
	endtask

	always @(posedge clk or negedge arst_n) begin
		synth_sample_t want;
		if (!arst_n) begin
			foreach (coef_bank[k]) coef_bank[k] = '0;
			foreach (a_hist[k]) begin
				a_hist[k] = '0;
				d_hist[k] = '0;
			end
			fill_cnt = 0;
			expected_samples.delete();
			err_cnt    = 0;
			n_items    = 0;
			n_restarts = 0;
			n_samples  = 0;
			n_clipped  = 0;
		end else begin
			// outputs first: a sample never belongs to an item taken at this edge
			if (m_axis_tvalid && m_axis_tready) begin
				n_samples++;
				if (m_axis_tuser)
					n_clipped++;
				if (expected_samples.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected sample: got %h last %b sat %b", $realtime,
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
				end else begin
					want = expected_samples.pop_front();
					if (m_axis_tdata !== want.sample || m_axis_tlast !== want.last ||
							m_axis_tuser !== want.sat)
						err_cnt++;
					if (m_axis_tdata !== want.sample)
						$display("%0t: out_sample: expected %h, got %h", $realtime,
							want.sample, m_axis_tdata);
					if (m_axis_tlast !== want.last)
						$display("%0t: out_last: expected %b, got %b", $realtime,
							want.last, m_axis_tlast);
					if (m_axis_tuser !== want.sat)
						$display("%0t: saturated: expected %b, got %b", $realtime,
							want.sat, m_axis_tuser);
				end
			end
			if (cfg_valid && cfg_ready)
				coef_bank[cfg_index] = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				n_items++;
				if (s_axis_tuser)
					n_restarts++;
				absorb_pair(s_axis_tdata[SMP_W-1:0], s_axis_tdata[2*SMP_W-1:SMP_W],
					s_axis_tuser);
			end
		end
		errors        <= err_cnt;
		pending       <= expected_samples.size();
		items_seen    <= n_items;
		restarts_seen <= n_restarts;
		samples_seen  <= n_samples;
		clipped_seen  <= n_clipped;
	end

endmodule

FILE: tb/sv/inverse_wavelet_synthesis_tb.sv
// inverse_wavelet_synthesis_tb: drives coefficient sets and coefficient pairs
// into inverse_wavelet_synthesis; checking lives in inverse_wavelet_synthesis_chk
`timescale 1ns / 100ps

module inverse_wavelet_synthesis_tb;

	import iws_pkg::*;

	localparam int TAPS         = 8;
	localparam int IDLE_PCT     = 36;    // chance in a hundred of an idle cycle
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 16;    // pipeline latency plus margin
	localparam int WATCHDOG     = 3000;  // cycles with no transfer at all
	localparam int N_PHASES     = 10;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [2*SMP_W-1:0]   s_axis_tdata = '0;   // approx_coef, detail_coef
	logic                 s_axis_tuser = 1'b0; // block_start
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [SMP_W-1:0]     m_axis_tdata;        // out_sample
	logic                 m_axis_tlast;        // out_last
	logic                 m_axis_tuser;        // saturated
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int errors, pending, items_seen, restarts_seen, samples_seen, clipped_seen;

	logic       no_idle  = 1'b0;  // both sides busy for one whole phase
	logic       hold_arm = 1'b0;  // asks the receiver for its one long hold-off
	logic [CFG_W-1:0] coef_plan [NUM_REGS];
	int         n_writes = 0;
	int         stall_cnt = 0;

	inverse_wavelet_synthesis #(.TAPS(TAPS)) i_dut (.*);

	inverse_wavelet_synthesis_chk #(.TAPS(TAPS)) i_chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// no transfer on any channel for too long means the block is hung
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random back-pressure, one long hold-off when asked
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_arm && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (no_idle)
				m_axis_tready <= 1'b1;
			else
				m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// random Q1.14 coefficient, full range or a narrow band around zero
	function automatic logic [SMP_W-1:0] rand_coef(input logic wide);
		if ($urandom_range(15) == 0)
			return $urandom_range(1) ? 16'h7FFF : 16'h8000;
		if (wide)
			return 16'($urandom);
		return 16'($urandom_range(4095)) - 16'd2048;
	endfunction

	// random coefficient value: extremes, full range or small
	function automatic logic [SMP_W-1:0] rand_sample();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			1: return 16'($urandom);
			default: return 16'($urandom_range(4095)) - 16'd2048;
		endcase
	endfunction

	// all eight tap registers back to back, valid held between writes
	task automatic load_taps();
		for (int k = 0; k < NUM_REGS; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_TAP0 + CFG_IDX_W'(k);
			cfg_data  <= coef_plan[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			n_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	// one coefficient pair transfer, with random idle cycles in front
	task automatic send_pair(input logic [SMP_W-1:0] a, input logic [SMP_W-1:0] d,
			input logic start);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {d, a};
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// wait for every predicted sample, then let warmup items clear the pipe
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int   n_items, burst;
		logic wide, bs;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tap 0 with unit f00/f01 so ties show, tap 7 at the extremes
		foreach (coef_plan[k]) coef_plan[k] = '0;
		coef_plan[0] = {16'h7FFF, 16'h8000, 16'h0001, 16'h0001};
		coef_plan[7] = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
		load_taps();
		// warmup of the first block, extremes and all-ones patterns
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		send_pair(16'h8000, 16'h7FFF, 1'b0);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'hFFFF, 16'hFFFF, 1'b0);
		send_pair(16'h0001, 16'h0001, 1'b0);
		send_pair(16'h7FFF, 16'h7FFF, 1'b0);
		// steady state: full-scale sums saturate both ways
		send_pair(16'h7FFF, 16'h7FFF, 1'b0);
		send_pair(16'h8000, 16'h8000, 1'b0);
		// exact half-way sums, plus and minus: both round towards plus
		send_pair(16'd8192, 16'h0000, 1'b0);
		send_pair(-16'sd8192, 16'h0000, 1'b0);
		send_pair(16'h0000, 16'h0001, 1'b0);
		// restart mid-block, short warmup, then another restart before it ends
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		send_pair(16'd100, -16'sd100, 1'b0);
		send_pair(-16'sd100, 16'd100, 1'b0);
		send_pair(16'h0001, 16'hFFFF, 1'b1);
		for (int k = 0; k < 8; k++)
			send_pair(k[0] ? 16'h8000 : 16'h7FFF, k[0] ? 16'h7FFF : 16'h8000, 1'b0);
		wait_idle();

		// random phases: all-max, all-min and zero taps, then random sets
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wide = ph[0];
			for (int k = 0; k < NUM_REGS; k++) begin
				case (ph)
					0: coef_plan[k] = {4{16'h7FFF}};
					1: coef_plan[k] = {4{16'h8000}};
					2: coef_plan[k] = '0;
					default: coef_plan[k] = {rand_coef(wide), rand_coef(wide),
						rand_coef(wide), rand_coef(wide)};
				endcase
			end
			load_taps();
			no_idle <= (ph == 4);
			n_items = (ph < 3) ? 60 : 140;
			burst   = 0;
			for (int i = 0; i < n_items; i++) begin
				// mostly long blocks, now and then a run of restarts
				if (burst == 0 && $urandom_range(199) == 0)
					burst = $urandom_range(4, 1);
				bs = (i == 0 && ph[1]) || burst > 0 || $urandom_range(49) == 0;
				if (burst > 0)
					burst--;
				if (ph == 6 && i == 30)
					hold_arm <= 1'b1;
				send_pair(rand_sample(), rand_sample(), bs);
			end
			wait_idle();
			no_idle <= 1'b0;
		end

		$display("run covered %0d items with %0d block restarts, %0d samples (%0d clipped)",
			items_seen, restarts_seen, samples_seen, clipped_seen);
		$display("over %0d tap sets (%0d register writes) and a %0d-cycle output hold-off",
			N_PHASES + 1, n_writes, HOLD_CYCLES);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
